// ===== rtl/core/tdm_pkg.sv =====
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared types, codes and constants of the task deadline monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package tdm_pkg;

    // Event codes carried in the slave-side tuser.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_RUN_START = 3'd1;
    localparam logic [2:0] OP_RUN_END   = 3'd2;
    localparam logic [2:0] OP_SUSPEND   = 3'd3;
    localparam logic [2:0] OP_RESUME    = 3'd4;
    localparam logic [2:0] OP_TERMINATE = 3'd5;
    localparam logic [2:0] OP_CLEAR     = 3'd6;

    // Task modes.
    localparam logic [1:0] MODE_READY      = 2'd0;
    localparam logic [1:0] MODE_RUNNING    = 2'd1;
    localparam logic [1:0] MODE_SUSPENDED  = 2'd2;
    localparam logic [1:0] MODE_TERMINATED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BASE_PRIO   = 2'd0;
    localparam logic [1:0] CFG_DEADLINE    = 2'd1;
    localparam logic [1:0] CFG_RECOVERABLE = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OP_W    = 3;
    localparam int S_DATA_W = 56;   // 49 payload bits padded to bytes
    localparam int M_DATA_W = 96;   // 91 payload bits padded to bytes

    localparam int PRIO_W    = 7;
    localparam int LIMIT_W   = 16;
    localparam int ELAPSED_W = 17;
    localparam int MISS_W    = 16;
    localparam int RUNS_W    = 32;
    localparam int SUM_W     = 48;
    localparam int MEAN_W    = 32;
    localparam int PROD_W    = PRIO_W + MISS_W;

    localparam logic [PRIO_W-1:0] PRIO_CAP = 7'd99;
    // b*misses*5/100 equals b*misses/20. Products of 2^11 or more give a term
    // above the cap, so only the low 11 bits are divided:
    // floor(n/20) = (n * 3277) >> 16, exact for n below 2^14.
    localparam int                     BOOST_IN_W  = 11;
    localparam int                     BOOST_RCP_W = 12;
    localparam logic [BOOST_RCP_W-1:0] BOOST_RECIP = 12'd3277;
    localparam int                     BOOST_SHIFT = 16;
    // floor(n/5) = (n * 0xCCCD) >> 18, exact for n below 2^18.
    localparam logic [15:0] RECIP5       = 16'hCCCD;
    localparam int          RECIP5_SHIFT = 18;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic mul;
        logic wr_prio;
        logic div_start;
        logic wr_mean;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tick_miss;
        logic            runs_nz;
        logic            div_done;
    } t_stat;

    function automatic logic [PRIO_W-1:0] eff_base(input logic [PRIO_W-1:0] b);
        eff_base = (b > PRIO_CAP) ? PRIO_CAP : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tdm_div.sv =====
// ----------------------------------------------------------------------------
// tdm_div
// Restoring divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tdm_pkg::SUM_W-1:0]  i_numer,
    input  wire logic [tdm_pkg::RUNS_W-1:0] i_denom,
    output logic                            o_done,
    output logic [tdm_pkg::SUM_W-1:0]       o_quot
);
    import tdm_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_q;
    logic [RUNS_W-1:0] r_rem;
    logic [RUNS_W-1:0] r_d;

    logic [RUNS_W:0]  rem_sh;
    logic             fits;
    logic [RUNS_W:0]  rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[SUM_W-1]};
        fits    = (rem_sh >= {1'b0, r_d});
        rem_sub = rem_sh - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_numer;
            r_rem <= '0;
            r_d   <= i_denom;
        end else if (r_busy) begin
            // The remainder stays below the divisor, so it fits in 32 bits.
            r_rem <= fits ? rem_sub[RUNS_W-1:0] : rem_sh[RUNS_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/tdm_dp.sv =====
// ----------------------------------------------------------------------------
// tdm_dp
// Datapath: configuration, task state, statistics and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tdm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tdm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [tdm_pkg::OP_W-1:0]       i_op,
    input  wire logic [tdm_pkg::S_DATA_W-1:0]   i_data,
    input  wire tdm_pkg::t_cmd                  i_cmd,
    output tdm_pkg::t_stat                      o_stat,
    output logic [tdm_pkg::M_DATA_W-1:0]        o_data
);
    import tdm_pkg::*;

    // Configuration.
    logic [PRIO_W-1:0]  r_base;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_recov;
    logic [LIMIT_W-1:0] r_thr;

    // Task state.
    logic [1:0]           r_mode;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [MISS_W-1:0]    r_misses;
    logic [RUNS_W-1:0]    r_runs;
    logic [SUM_W-1:0]     r_sum;
    logic [MEAN_W-1:0]    r_mean;
    logic [PRIO_W-1:0]    r_prio;
    logic                 r_miss;

    // Latched input word and intermediate product.
    logic [OP_W-1:0]    r_op;
    logic [LIMIT_W-1:0] r_el_in;
    logic [RUNS_W-1:0]  r_rt;
    logic               r_fail;
    logic [PROD_W-1:0]  r_prod;

    logic [M_DATA_W-1:0] r_out;

    logic [ELAPSED_W:0]   tick_sum;
    logic [ELAPSED_W-1:0] tick_sat;
    logic                 tick_miss;
    logic [SUM_W:0]       sum_ext;
    logic [33:0]          thr_prod;
    logic                 near;
    logic                 div_done;
    logic [SUM_W-1:0]     div_quot;
    logic                 boost_big;
    logic [BOOST_IN_W+BOOST_RCP_W-1:0] boost_prod;
    logic [PRIO_W-1:0]    boost_q;
    logic [PRIO_W:0]      prio_sum;
    logic [PRIO_W-1:0]    prio_new;
    logic [MEAN_W-1:0]    mean_new;

    always_comb begin
        tick_sum  = {1'b0, r_elapsed} + {2'b0, r_el_in};
        tick_sat  = tick_sum[ELAPSED_W] ? '1 : tick_sum[ELAPSED_W-1:0];
        tick_miss = (r_op == OP_TICK) && (r_limit != '0)
                    && (tick_sat > {1'b0, r_limit});
        sum_ext   = {1'b0, r_sum} + {17'b0, r_rt};
        thr_prod  = {r_limit, 2'b00} * RECIP5;
        near      = (r_limit != '0) && (r_elapsed > {1'b0, r_thr});

        boost_big  = (r_prod[PROD_W-1:BOOST_IN_W] != '0);
        boost_prod = r_prod[BOOST_IN_W-1:0] * BOOST_RECIP;
        boost_q    = boost_prod[BOOST_SHIFT+PRIO_W-1:BOOST_SHIFT];
        prio_sum   = {1'b0, eff_base(r_base)} + {1'b0, boost_q};
        if (boost_big || (prio_sum > {1'b0, PRIO_CAP})) begin
            prio_new = PRIO_CAP;
        end else begin
            prio_new = prio_sum[PRIO_W-1:0];
        end
        mean_new = (div_quot[SUM_W-1:MEAN_W] != '0) ? '1 : div_quot[MEAN_W-1:0];
    end

    tdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (r_sum),
        .i_denom (r_runs),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= 7'd1;
            r_limit   <= '0;
            r_recov   <= 1'b1;
            r_mode    <= MODE_READY;
            r_elapsed <= '0;
            r_misses  <= '0;
            r_runs    <= '0;
            r_sum     <= '0;
            r_mean    <= '0;
            r_prio    <= 7'd1;
            r_miss    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BASE_PRIO: begin
                        r_base <= i_cfg_data[PRIO_W-1:0];
                        r_prio <= eff_base(i_cfg_data[PRIO_W-1:0]);
                    end
                    CFG_DEADLINE:    r_limit <= i_cfg_data;
                    CFG_RECOVERABLE: r_recov <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.exec) begin
                r_miss <= tick_miss;
                unique case (r_op)
                    OP_TICK: begin
                        if (r_limit != '0) begin
                            if (tick_miss) begin
                                r_elapsed <= '0;
                                if (r_misses != '1) begin
                                    r_misses <= r_misses + 1'b1;
                                end
                            end else begin
                                r_elapsed <= tick_sat;
                            end
                        end
                    end
                    OP_RUN_START: begin
                        r_mode    <= MODE_RUNNING;
                        r_runs    <= r_runs + 1'b1;
                        r_elapsed <= '0;
                    end
                    OP_RUN_END: begin
                        r_mode <= (r_fail && !r_recov) ? MODE_TERMINATED : MODE_READY;
                        r_sum  <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                    end
                    OP_SUSPEND: begin
                        if (r_mode != MODE_TERMINATED) begin
                            r_mode <= MODE_SUSPENDED;
                        end
                    end
                    OP_RESUME: begin
                        if (r_mode == MODE_SUSPENDED) begin
                            r_mode <= MODE_READY;
                        end
                    end
                    OP_TERMINATE: r_mode <= MODE_TERMINATED;
                    OP_CLEAR: begin
                        r_runs    <= '0;
                        r_misses  <= '0;
                        r_sum     <= '0;
                        r_mean    <= '0;
                        r_elapsed <= '0;
                        r_prio    <= eff_base(r_base);
                    end
                    default: ;
                endcase
            end

            if (i_cmd.wr_prio) begin
                r_prio <= prio_new;
            end
            if (i_cmd.wr_mean) begin
                r_mean <= mean_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr <= thr_prod[RECIP5_SHIFT+LIMIT_W-1:RECIP5_SHIFT];
        if (i_cmd.load_in) begin
            r_op    <= i_op;
            r_el_in <= i_data[15:0];
            r_rt    <= i_data[47:16];
            r_fail  <= i_data[48];
        end
        if (i_cmd.mul) begin
            r_prod <= eff_base(r_base) * r_misses;
        end
        if (i_cmd.load_out) begin
            r_out <= {5'b0, r_mean, r_runs, r_misses, near, r_miss, r_prio, r_mode};
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.tick_miss = tick_miss;
    assign o_stat.runs_nz   = (r_runs != '0);
    assign o_stat.div_done  = div_done;
    assign o_data           = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/tdm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdm_ctrl
// Controller: sequences one event through the datapath and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tdm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire tdm_pkg::t_stat i_stat,
    output tdm_pkg::t_cmd       o_cmd
);
    import tdm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_BOOST,
        ST_DSTART,
        ST_DWAIT,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_comb begin
        n_state    = r_state;
        n_out_vld  = r_out_vld && !i_out_ready;
        o_cmd      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.op == OP_TICK && i_stat.tick_miss) begin
                    n_state = ST_MUL;
                end else if (i_stat.op == OP_RUN_END && i_stat.runs_nz) begin
                    n_state = ST_DSTART;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_BOOST;
            end
            ST_BOOST: begin
                o_cmd.wr_prio = 1'b1;
                n_state       = ST_FIN;
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_mean = 1'b1;
                    n_state       = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold the finished word until the result register is free.
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

// ===== rtl/core/task_deadline_monitor.sv =====
// ----------------------------------------------------------------------------
// task_deadline_monitor
// Deadline supervision, run statistics and priority boost for one task.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                       Contents
//  s_axis    in         tvalid/tready/tdata/tuser   one event word
//  m_axis    out        tvalid/tready/tdata         one result word per event
//  cfg       in         i_cfg_we/idx/data           base priority, deadline,
//                                                   recoverable flag
//
//  A plain event is executed and its result loaded; a tick that misses its
//  deadline also passes a multiply and a priority write (the boost term
//  b*misses/20 is a reciprocal multiply). A run end with a nonzero run count
//  also waits on the 48-step restoring divider for the mean run time. One
//  event is in work at a time; the next word is taken the cycle after a
//  result is loaded, and a finished word waits while m_axis still holds the
//  previous one. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`default_nettype none

module task_deadline_monitor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tdm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tdm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // elapsed_ms[15:0], run_time_us[47:16], run_failed[48], zero pad
    input  wire logic [tdm_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // opcode[2:0]
    input  wire logic [tdm_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // task_status[1:0], current_priority[8:2], miss_now[9], near_deadline[10],
    // misses_total[26:11], runs_total[58:27], mean_run_time[90:59], zero pad
    output logic [tdm_pkg::M_DATA_W-1:0]        m_axis_tdata
);
    import tdm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tdm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire
